FILE: rtl/rgbf_pkg.sv
// Shared types, constants and the LED word packing for the LED frame generator.
// Used by every module under rtl; depends on nothing.
package rgbf_pkg;

  localparam int unsigned LED_COUNT_DEFAULT = 12;
  localparam int unsigned CMD_FIFO_DEPTH    = 2;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned COUNTDOWN_W = 17;
  localparam int unsigned BRIGHT_W    = 5;
  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned WORD_W      = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_UPDATE_PERIOD     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GLOBAL_BRIGHTNESS = 8'd1;

  localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RESET = 16'd10;
  localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET    = 5'd31;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd1;

  localparam logic [2:0]        LED_PREFIX = 3'b111;
  localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
  localparam logic [WORD_W-1:0] STOP_WORD  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    COLOR_RED   = 2'd0,
    COLOR_GREEN = 2'd1,
    COLOR_BLUE  = 2'd2
  } color_e;

  // One frame job handed from the front end to the word sequencer
  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic [LEVEL_W-1:0]  blue;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  red;
  } led_cmd_t;

  function automatic logic [WORD_W-1:0] led_word(input led_cmd_t cmd);
    led_word = {LED_PREFIX, cmd.brightness, cmd.blue, cmd.green, cmd.red};
  endfunction

endpackage

FILE: rtl/rgbf_front.sv
// Front end: configuration registers, tick countdown and fade state machine.
// Turns each firing tick into one frame job. Depends on rgbf_pkg.
module rgbf_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rgbf_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [rgbf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               tick_valid_i,
  input  logic                               tick_i,
  output logic                               cmd_push_o,
  output rgbf_pkg::led_cmd_t                 cmd_o
);

  logic [rgbf_pkg::PERIOD_W-1:0]    period_q;
  logic [rgbf_pkg::BRIGHT_W-1:0]    bright_q;
  logic [rgbf_pkg::COUNTDOWN_W-1:0] countdown_q, countdown_d;
  logic [rgbf_pkg::LEVEL_W-1:0]     level_q, level_d;
  logic                             down_q, down_d;
  rgbf_pkg::color_e                 color_q, color_d;
  logic                             tick_acc;
  logic                             fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= rgbf_pkg::UPDATE_PERIOD_RESET;
      bright_q <= rgbf_pkg::BRIGHTNESS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rgbf_pkg::REG_UPDATE_PERIOD:     period_q <= cfg_data_i[rgbf_pkg::PERIOD_W-1:0];
        rgbf_pkg::REG_GLOBAL_BRIGHTNESS: bright_q <= cfg_data_i[rgbf_pkg::BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_acc = tick_valid_i && tick_i;
  assign fire     = tick_acc && (countdown_q == '0);

  always_comb begin
    countdown_d = countdown_q;
    level_d     = level_q;
    down_d      = down_q;
    color_d     = color_q;
    if (tick_acc && !fire) begin
      countdown_d = countdown_q - rgbf_pkg::COUNTDOWN_W'(1);
    end
    if (fire) begin
      countdown_d = {1'b0, period_q};
      if (!down_q) begin
        if (level_q == rgbf_pkg::LEVEL_MAX) begin
          down_d = 1'b1;
        end else begin
          level_d = level_q + rgbf_pkg::LEVEL_W'(1);
        end
      end else if (level_q <= rgbf_pkg::LEVEL_MIN) begin
        // bottom of the ramp: turn round and rotate the colour
        level_d = rgbf_pkg::LEVEL_MIN;
        down_d  = 1'b0;
        unique case (color_q)
          rgbf_pkg::COLOR_RED:   color_d = rgbf_pkg::COLOR_GREEN;
          rgbf_pkg::COLOR_GREEN: color_d = rgbf_pkg::COLOR_BLUE;
          default:               color_d = rgbf_pkg::COLOR_RED;
        endcase
      end else begin
        level_d = level_q - rgbf_pkg::LEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= '0;
      level_q     <= '0;
      down_q      <= 1'b0;
      color_q     <= rgbf_pkg::COLOR_RED;
    end else begin
      countdown_q <= countdown_d;
      level_q     <= level_d;
      down_q      <= down_d;
      color_q     <= color_d;
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.brightness = bright_q;
    unique case (color_q)
      rgbf_pkg::COLOR_RED:   cmd_o.red   = level_q;
      rgbf_pkg::COLOR_GREEN: cmd_o.green = level_q;
      rgbf_pkg::COLOR_BLUE:  cmd_o.blue  = level_q;
      default: ;
    endcase
  end

  assign cmd_push_o = fire;

endmodule

FILE: rtl/rgbf_cmd_fifo.sv
// Short queue of frame jobs between the front end and the word sequencer.
// Register-based, depth from rgbf_pkg. Depends on rgbf_pkg.
module rgbf_cmd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rgbf_pkg::led_cmd_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output rgbf_pkg::led_cmd_t rdata_o
);

  localparam int unsigned Depth = rgbf_pkg::CMD_FIFO_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rgbf_pkg::led_cmd_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

FILE: rtl/rgbf_back.sv
// Word sequencer: expands one frame job into start word, LED words and stop word,
// one word a cycle while the output register is empty or popped. Depends on rgbf_pkg.
module rgbf_back #(
  parameter int unsigned LedCount = rgbf_pkg::LED_COUNT_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  rgbf_pkg::led_cmd_t            cmd_i,
  output logic                          cmd_pop_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [rgbf_pkg::WORD_W-1:0]   frame_word_o,
  output logic                          last_word_o
);

  localparam int unsigned CntW = $clog2(LedCount + 2);

  logic [CntW-1:0]               cnt_q, cnt_d;
  logic                          valid_q, valid_d;
  logic [rgbf_pkg::WORD_W-1:0]   word_q, word_d;
  logic                          last_q, last_d;
  logic                          advance;

  // the output register can take a new word when empty or being drained
  assign advance = !valid_q || pop;

  always_comb begin
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    word_d    = word_q;
    last_d    = last_q;
    cmd_pop_o = 1'b0;
    if (advance) begin
      valid_d = !cmd_empty_i;
      if (!cmd_empty_i) begin
        if (cnt_q == '0) begin
          word_d = rgbf_pkg::START_WORD;
          last_d = 1'b0;
          cnt_d  = cnt_q + CntW'(1);
        end else if (cnt_q == CntW'(LedCount + 1)) begin
          word_d    = rgbf_pkg::STOP_WORD;
          last_d    = 1'b1;
          cnt_d     = '0;
          cmd_pop_o = 1'b1;
        end else begin
          word_d = rgbf_pkg::led_word(cmd_i);
          last_d = 1'b0;
          cnt_d  = cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    last_q <= last_d;
  end

  assign empty        = !valid_q;
  assign frame_word_o = word_q;
  assign last_word_o  = last_q;

endmodule

FILE: rtl/rgb_fade_led_frame_generator_top.sv
// LED frame generator with colour fade: top level.
// Instantiates rgbf_front, rgbf_cmd_fifo and rgbf_back; depends on rgbf_pkg.
//
// Input channel: push / full, one ms_tick_i bit per transfer. A tick with
// ms_tick_i low is taken and ignored. The first tick after reset fires a frame,
// then every (update_period+1)th tick does.
// Output channel: empty / pop. A frame is LedCount+2 transfers: a start word of
// zeros, LedCount LED words {111, brightness, blue, green, red}, and a stop word
// of ones with last_word_o set.
// Configuration: cfg_valid_i / cfg_ready_o (always ready), index 0 is
// update_period, index 1 is global_brightness, other indexes are dropped.
// Ticks are taken in every cycle while the two-entry job queue has room; a full
// queue holds off every tick, firing or not. A firing tick's job enters the
// queue at the edge that takes the tick, and the sequencer output register then
// loads the start word, then one word a cycle while pop stays high.
// When the receiver stalls the output word holds, the queue fills and full
// rises after two pending frames. Reset empties the queue, restores the
// register defaults and restarts the fade at red, level zero.
module rgb_fade_led_frame_generator_top #(
  parameter int unsigned LedCount = rgbf_pkg::LED_COUNT_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [rgbf_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [rgbf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic                               ms_tick_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [rgbf_pkg::WORD_W-1:0]        frame_word_o,
  output logic                               last_word_o
);

  logic               cmd_push, cmd_pop, cmd_empty, cmd_full;
  rgbf_pkg::led_cmd_t cmd_wdata, cmd_rdata;
  logic               tick_valid;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;
  assign tick_valid  = push && !cmd_full;

  rgbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tick_valid_i(tick_valid),
    .tick_i      (ms_tick_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_wdata)
  );

  rgbf_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_wdata),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(cmd_rdata)
  );

  rgbf_back #(
    .LedCount(LedCount)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rdata),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .frame_word_o(frame_word_o),
    .last_word_o (last_word_o)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the LED frame generator with colour fade.
// Drives ticks and register writes into rgb_fade_led_frame_generator_top and
// checks every frame word. Depends on rgbf_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    logic [rgbf_pkg::WORD_W-1:0] word;
    logic                        last;
  } frame_word_t;

  // Tracks the fade state and holds the words each firing tick should produce
  class frame_scoreboard;
    logic [rgbf_pkg::PERIOD_W-1:0]    period;
    logic [rgbf_pkg::BRIGHT_W-1:0]    bright;
    logic [rgbf_pkg::COUNTDOWN_W-1:0] countdown;
    logic [rgbf_pkg::LEVEL_W-1:0]     level;
    bit                               falling;
    rgbf_pkg::color_e                 colour;
    frame_word_t                      pending_words[$];
    int unsigned                      errors;

    function new();
      period    = rgbf_pkg::UPDATE_PERIOD_RESET;
      bright    = rgbf_pkg::BRIGHTNESS_RESET;
      countdown = '0;
      level     = '0;
      falling   = 1'b0;
      colour    = rgbf_pkg::COLOR_RED;
      errors    = 0;
    endfunction

    function void write_reg(logic [rgbf_pkg::CFG_INDEX_W-1:0] idx,
                            logic [rgbf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        rgbf_pkg::REG_UPDATE_PERIOD:     period = data;
        rgbf_pkg::REG_GLOBAL_BRIGHTNESS: bright = data[rgbf_pkg::BRIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void step_fade();
      if (!falling) begin
        if (level == rgbf_pkg::LEVEL_MAX) falling = 1'b1;
        else level = level + 1'b1;
      end else if (level <= rgbf_pkg::LEVEL_MIN) begin
        // bottom of the ramp: turn upwards and move on to the next colour
        level   = rgbf_pkg::LEVEL_MIN;
        falling = 1'b0;
        colour  = (colour == rgbf_pkg::COLOR_BLUE) ? rgbf_pkg::COLOR_RED :
                  rgbf_pkg::color_e'(colour + 1'b1);
      end else begin
        level = level - 1'b1;
      end
    endfunction

    function void note_tick(logic tick);
      logic [rgbf_pkg::LEVEL_W-1:0] red, green, blue;
      logic [rgbf_pkg::WORD_W-1:0]  led;
      if (!tick) return;
      if (countdown != '0) begin
        countdown = countdown - 1'b1;
        return;
      end
      countdown = {1'b0, period};
      red   = '0;
      green = '0;
      blue  = '0;
      case (colour)
        rgbf_pkg::COLOR_RED:   red   = level;
        rgbf_pkg::COLOR_GREEN: green = level;
        rgbf_pkg::COLOR_BLUE:  blue  = level;
        default: ;
      endcase
      led = {rgbf_pkg::LED_PREFIX, bright, blue, green, red};
      pending_words.push_back('{rgbf_pkg::START_WORD, 1'b0});
      repeat (rgbf_pkg::LED_COUNT_DEFAULT) pending_words.push_back('{led, 1'b0});
      pending_words.push_back('{rgbf_pkg::STOP_WORD, 1'b1});
      step_fade();
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_word(logic [rgbf_pkg::WORD_W-1:0] word, logic last);
      frame_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %h last %b", word, last));
        return;
      end
      want = pending_words.pop_front();
      if (word !== want.word)
        report($sformatf("frame_word %h, wanted %h", word, want.word));
      if (last !== want.last)
        report($sformatf("last_word %b, wanted %b on word %h", last, want.last, want.word));
    endtask
  endclass

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [rgbf_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [rgbf_pkg::CFG_DATA_W-1:0]  cfg_data_i;
  logic                             push;
  logic                             full;
  logic                             ms_tick_i;
  logic                             empty;
  logic                             pop;
  logic [rgbf_pkg::WORD_W-1:0]      frame_word_o;
  logic                             last_word_o;

  frame_scoreboard sb;
  int unsigned     rx_max_gap;
  int unsigned     rx_hold;

  rgb_fade_led_frame_generator_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .ms_tick_i   (ms_tick_i),
    .empty       (empty),
    .pop         (pop),
    .frame_word_o(frame_word_o),
    .last_word_o (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("rgb_fade_led_frame_generator_top verification failed");
    $finish;
  end

  // push stays high from one transfer to the next when there is no gap
  task automatic send_tick(input logic tick, input int unsigned gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    ms_tick_i <= tick;
    do @(posedge clk_i); while (full);
    sb.note_tick(tick);
  endtask

  task automatic cfg_write(input logic [rgbf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [rgbf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(input logic [rgbf_pkg::CFG_DATA_W-1:0] period,
                              input logic [rgbf_pkg::CFG_DATA_W-1:0] bright);
    cfg_write(rgbf_pkg::REG_UPDATE_PERIOD, period);
    cfg_write(rgbf_pkg::REG_GLOBAL_BRIGHTNESS, bright);
    cfg_valid_i <= 1'b0;
  endtask

  // drain every frame, then allow for a non-firing tick still in flight
  task automatic settle();
    push <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_ticks(input int unsigned count, input int unsigned hold_at);
    int unsigned n;
    int unsigned gap;
    for (n = 0; n < count; n++) begin
      if (n == hold_at) rx_hold = 400;
      gap = ((n / 20) % 3 == 0) ? 0 : $urandom_range(0, 15);
      send_tick($urandom_range(0, 3) != 0, gap);
    end
  endtask

  initial begin : frame_reader
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    pop   = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_hold != 0) begin
        // hold off long enough for the job queue to fill and stall the ticks
        pop <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end
      gap = (rx_max_gap == 0 || (taken / 24) % 3 == 0) ? 0 : $urandom_range(0, rx_max_gap);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_word(frame_word_o, last_word_o);
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned n;
    sb          = new();
    rst_ni      = 1'b0;
    push        = 1'b0;
    ms_tick_i   = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rx_max_gap  = 15;
    rx_hold     = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: idle tick, first tick fires, then a full countdown
    send_tick(1'b0, 0);
    send_tick(1'b1, 0);
    send_tick(1'b0, 3);
    for (n = 0; n < 10; n++) send_tick(1'b1, n % 2);
    send_tick(1'b1, 0);
    send_tick(1'b0, 0);
    settle();

    // every tick fires, brightness off
    apply_config(16'h0000, 16'h0000);
    for (n = 0; n < 3; n++) send_tick(1'b1, 0);
    send_tick(1'b0, 0);
    settle();

    // writes to unknown indexes must leave the registers alone
    cfg_write(8'd2, 16'hFFFF);
    cfg_write(8'hFF, 16'h0000);
    cfg_valid_i <= 1'b0;
    send_tick(1'b1, 0);
    settle();

    apply_config(16'h0001, 16'hFFFF);
    random_ticks(110, 110);
    settle();

    // every tick fires back to back with the receiver always ready
    rx_max_gap = 0;
    apply_config(16'h0000, 16'($urandom()));
    for (n = 0; n < 20; n++) send_tick(1'b1, 0);
    settle();

    rx_max_gap = 15;
    apply_config(16'h0003, 16'($urandom()));
    random_ticks(110, 30);
    settle();

    // longer period: reload and count all the way down to the next frame
    apply_config(16'd20, 16'h0011);
    while (sb.countdown != '0) send_tick(1'b1, 0);
    for (n = 0; n < 22; n++) send_tick(1'b1, 0);
    settle();

    if (sb.errors == 0) begin
      $display("rgb_fade_led_frame_generator_top verification clean");
    end else begin
      $display("rgb_fade_led_frame_generator_top verification failed");
    end
    $finish;
  end

endmodule

FILE: rgb_fade_led_frame_generator_top.f
rtl/rgbf_pkg.sv
rtl/rgbf_front.sv
rtl/rgbf_cmd_fifo.sv
rtl/rgbf_back.sv
rtl/rgb_fade_led_frame_generator_top.sv
sim/tb_top.sv
